FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: src/asfs_pkg.sv
// ---------------------------------------------------------------------------
// asfs_pkg
// types, constants and header helpers of the adts frame scanner
// ---------------------------------------------------------------------------
package asfs_pkg;

	localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
	localparam logic [3:0]  SYNC_NIBBLE    = 4'hF;
	localparam logic [3:0]  RATE_COUNT     = 4'd13;
	localparam logic [12:0] MIN_FRAME_LEN  = 13'd7;
	localparam logic [3:0]  HDR_LEN_NO_CRC = 4'd7;
	localparam logic [3:0]  HDR_LEN_CRC    = 4'd9;
	localparam logic [28:0] ID3_HDR_LEN    = 29'd10;
	localparam logic [7:0]  CH_I = 8'h49;
	localparam logic [7:0]  CH_D = 8'h44;
	localparam logic [7:0]  CH_3 = 8'h33;
	localparam logic [7:0]  CH_F = 8'h66;
	localparam logic [7:0]  CH_T = 8'h74;
	localparam logic [7:0]  CH_Y = 8'h79;
	localparam logic [7:0]  CH_P = 8'h70;
	localparam logic [3:0]  PROBE_HDR_FILL  = 4'd7;
	localparam logic [3:0]  PROBE_TAG_FILL  = 4'd10;
	localparam logic [3:0]  PROBE_LAST_FILL = 4'd12;
	localparam logic [31:0] MP4_MIN_BYTES   = 32'd12;
	localparam logic [9:0]  MS_PER_SECOND   = 10'd1000;
	localparam int          FRAME_SHIFT     = 10;

	localparam logic KIND_FRAME   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [2:0] STS_FULL     = 3'd0;
	localparam logic [2:0] STS_FULL_TAG = 3'd1;
	localparam logic [2:0] STS_PARTIAL  = 3'd2;
	localparam logic [2:0] STS_HDR_ONLY = 3'd3;
	localparam logic [2:0] STS_MP4      = 3'd4;
	localparam logic [2:0] STS_UNSUP    = 3'd5;
	localparam logic [2:0] STS_EMPTY    = 3'd6;

	typedef struct packed {
		logic        pa;
		logic [1:0]  profile;
		logic [3:0]  idx;
		logic [2:0]  ch;
		logic [12:0] len;
	} asfs_fields_t;

	typedef struct packed {
		logic         ok;
		asfs_fields_t f;
	} asfs_hdr_t;

	typedef struct packed {
		logic        kind;
		logic        last;
		logic [2:0]  status;
		logic [2:0]  profile;
		logic [3:0]  rate_index;
		logic [16:0] sample_hz;
		logic [2:0]  channel_config;
		logic [12:0] frame_bytes;
		logic [3:0]  header_bytes;
		logic [31:0] frames_counted;
		logic [31:0] play_ms;
	} asfs_res_t;

	typedef struct packed {
		logic take;
		logic eos;
		logic load_frame;
		logic load_sum;
	} asfs_cmd_t;

	typedef struct packed {
		logic frame_done;
		logic out_valid;
	} asfs_sts_t;

	function automatic logic [16:0] rate_hz(input logic [3:0] idx);
		logic [16:0] r;
		case (idx)
			4'd0: r = 17'd96000;
			4'd1: r = 17'd88200;
			4'd2: r = 17'd64000;
			4'd3: r = 17'd48000;
			4'd4: r = 17'd44100;
			4'd5: r = 17'd32000;
			4'd6: r = 17'd24000;
			4'd7: r = 17'd22050;
			4'd8: r = 17'd16000;
			4'd9: r = 17'd12000;
			4'd10: r = 17'd11025;
			4'd11: r = 17'd8000;
			4'd12: r = 17'd7350;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	function automatic asfs_hdr_t parse_hdr(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] b4,
		input logic [7:0] b5);
		asfs_hdr_t h;
		h.f.pa      = b1[0];
		h.f.profile = b2[7:6];
		h.f.idx     = b2[5:2];
		h.f.ch      = {b2[0], b3[7:6]};
		h.f.len     = {b3[1:0], b4, b5[7:5]};
		h.ok = (b0 == SYNC_BYTE) && (b1[7:4] == SYNC_NIBBLE) && (h.f.idx < RATE_COUNT) &&
			(h.f.ch != 3'd0) && (h.f.len >= MIN_FRAME_LEN);
		return h;
	endfunction

endpackage

FILE: src/asfs_div.sv
// ---------------------------------------------------------------------------
// asfs_div
// duration unit: frames*1024000 / rate, restoring division one bit a cycle
// ---------------------------------------------------------------------------
module asfs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] frames,
	input  logic [16:0] rate,
	output logic        done,
	output logic [31:0] quo
);

	localparam int PW = 32 + 10;
	localparam int DW = PW + asfs_pkg::FRAME_SHIFT;
	localparam int CW = $clog2(DW);

	logic [DW-1:0] dvd_q;
	logic [16:0]   rem_q;
	logic [16:0]   dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [17:0]   trial;
	logic [17:0]   diff;
	logic          ge;
	logic [PW-1:0] prod;

	assign prod  = PW'(frames) * PW'(asfs_pkg::MS_PER_SECOND);
	assign trial = {rem_q, dvd_q[DW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(DW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {prod, {asfs_pkg::FRAME_SHIFT{1'b0}}};
			rem_q <= '0;
			dsr_q <= rate;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= ge ? diff[16:0] : trial[16:0];
		end
	end

	assign done = done_q;
	assign quo  = dvd_q[31:0];

endmodule

FILE: src/asfs_ctrl.sv
// ---------------------------------------------------------------------------
// asfs_ctrl
// controller: byte intake, summary sequencing and result register loads
// ---------------------------------------------------------------------------
module asfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tlast,
	input  logic                m_tready,
	input  asfs_pkg::asfs_sts_t sts,
	input  logic                div_done,
	output logic                s_tready,
	output asfs_pkg::asfs_cmd_t cmd,
	output logic                div_start
);

	typedef enum logic [3:0] {
		ST_RUN   = 4'b0001,
		ST_START = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_SUM   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_free;

	assign out_free  = !sts.out_valid || m_tready;
	assign s_tready  = (state_q == ST_RUN) && out_free;
	assign div_start = state_q == ST_START;

	always_comb begin
		cmd.take       = s_tvalid && s_tready;
		cmd.eos        = s_tlast;
		cmd.load_frame = cmd.take && sts.frame_done;
		cmd.load_sum   = (state_q == ST_SUM) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (cmd.take && s_tlast) state_d = ST_START;
			end
			ST_START: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) state_d = ST_SUM;
			end
			ST_SUM: begin
				if (out_free) state_d = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/asfs_dp.sv
// ---------------------------------------------------------------------------
// asfs_dp
// datapath: probe window, tag skip, frame walk, summary snapshot, result register
// ---------------------------------------------------------------------------
module asfs_dp #(
	parameter int PROBE_WINDOW_BYTES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic                has_byte,
	input  asfs_pkg::asfs_cmd_t cmd,
	input  logic                m_tready,
	input  logic [31:0]         dur,
	output asfs_pkg::asfs_sts_t sts,
	output asfs_pkg::asfs_res_t res,
	output logic [31:0]         div_frames,
	output logic [16:0]         div_rate
);

	localparam int IW = $clog2(PROBE_WINDOW_BYTES);

	typedef enum logic [4:0] {
		PH_PROBE  = 5'b00001,
		PH_SKIP   = 5'b00010,
		PH_FRAMES = 5'b00100,
		PH_MP4    = 5'b01000,
		PH_UNSUP  = 5'b10000
	} phase_t;

	logic [31:0]            pos_q, n_pos;
	logic [7:0]             probe_q [PROBE_WINDOW_BYTES];
	logic [7:0]             win     [PROBE_WINDOW_BYTES];
	logic [7:0]             hdr_q   [7];
	logic [7:0]             hbuf    [7];
	logic [28:0]            tag_q, n_tag;
	phase_t                 phase_q, n_phase;
	logic [12:0]            left_q, n_left;
	logic [31:0]            total_q, n_total;
	asfs_pkg::asfs_fields_t first_q, n_first;
	asfs_pkg::asfs_fields_t cur_q, n_cur;
	logic                   stopped_q, n_stopped;
	logic [3:0]             fill_q, n_fill, nf;
	logic                   ftyp_q, n_ftyp;
	logic                   frame_done;
	logic                   do_start;
	logic                   probe_ftyp;
	logic                   is_id3;
	asfs_pkg::asfs_hdr_t    ph;
	logic [3:0]             hl;
	logic [2:0]             sum_st;
	logic [2:0]             sum_st_q;
	logic                   sum_adts_q;
	asfs_pkg::asfs_fields_t sum_first_q;
	logic [31:0]            sum_frames_q;
	asfs_pkg::asfs_res_t    res_q;
	logic                   out_valid_q;

	function automatic asfs_pkg::asfs_res_t make_res(input logic kind, input logic [2:0] st,
		input logic adts, input asfs_pkg::asfs_fields_t f, input logic [31:0] fr,
		input logic [31:0] d, input logic last);
		asfs_pkg::asfs_res_t r;
		r.kind           = kind;
		r.last           = last;
		r.status         = st;
		r.profile        = adts ? ({1'b0, f.profile} + 3'd1) : 3'd0;
		r.rate_index     = adts ? f.idx : 4'd0;
		r.sample_hz      = adts ? asfs_pkg::rate_hz(f.idx) : 17'd0;
		r.channel_config = adts ? f.ch : 3'd0;
		r.frame_bytes    = adts ? f.len : 13'd0;
		r.header_bytes   = adts ? (f.pa ? asfs_pkg::HDR_LEN_NO_CRC : asfs_pkg::HDR_LEN_CRC) :
			4'd0;
		r.frames_counted = fr;
		r.play_ms        = d;
		return r;
	endfunction

	assign probe_ftyp = (win[4] == asfs_pkg::CH_F) && (win[5] == asfs_pkg::CH_T) &&
		(win[6] == asfs_pkg::CH_Y) && (win[7] == asfs_pkg::CH_P);
	assign is_id3 = (win[0] == asfs_pkg::CH_I) && (win[1] == asfs_pkg::CH_D) &&
		(win[2] == asfs_pkg::CH_3) &&
		(((win[6] | win[7] | win[8] | win[9]) & 8'h80) == 8'h00);

	always_comb begin
		win       = probe_q;
		hbuf      = hdr_q;
		n_pos     = pos_q;
		n_tag     = tag_q;
		n_phase   = phase_q;
		n_left    = left_q;
		n_total   = total_q;
		n_first   = first_q;
		n_cur     = cur_q;
		n_stopped = stopped_q;
		n_fill    = fill_q;
		n_ftyp    = ftyp_q;
		nf        = fill_q + 4'd1;
		do_start  = 1'b0;
		frame_done = 1'b0;
		if (cmd.take && has_byte) begin
			n_pos = pos_q + 32'd1;
			if (phase_q == PH_PROBE && {1'b0, fill_q} < 5'(PROBE_WINDOW_BYTES)) begin
				win[fill_q[IW-1:0]] = data_byte;
			end
			if (phase_q == PH_SKIP && pos_q == {3'b000, tag_q}) begin
				win[0] = data_byte;
			end
			if (phase_q == PH_FRAMES && !stopped_q && left_q == 13'd0 && fill_q < 4'd7) begin
				hbuf[fill_q[2:0]] = data_byte;
			end
		end
		if (phase_q == PH_FRAMES) begin
			ph = asfs_pkg::parse_hdr(hbuf[0], hbuf[1], hbuf[2], hbuf[3], hbuf[4], hbuf[5]);
		end else begin
			ph = asfs_pkg::parse_hdr(win[0], win[1], win[2], win[3], win[4], win[5]);
		end
		if (cmd.take && has_byte) begin
			case (phase_q)
				PH_PROBE: begin
					n_fill = nf;
					if (nf == asfs_pkg::PROBE_HDR_FILL && ph.ok) begin
						n_first = ph.f;
						for (int i = 0; i < 7; i++) hbuf[i] = win[i];
						n_phase  = PH_FRAMES;
						do_start = 1'b1;
					end else if (nf == asfs_pkg::PROBE_TAG_FILL && tag_q == 29'd0 && is_id3) begin
						n_tag = {1'b0, win[6][6:0], win[7][6:0], win[8][6:0], win[9][6:0]} +
							asfs_pkg::ID3_HDR_LEN;
						n_ftyp  = probe_ftyp;
						n_phase = PH_SKIP;
						n_fill  = 4'd0;
					end else if (nf == asfs_pkg::PROBE_LAST_FILL) begin
						n_phase = probe_ftyp ? PH_MP4 : PH_UNSUP;
					end
				end
				PH_SKIP: begin
					if (pos_q == {3'b000, tag_q}) begin
						n_fill  = 4'd1;
						n_phase = PH_PROBE;
					end
				end
				PH_FRAMES: begin
					if (!stopped_q) begin
						if (left_q == 13'd0) begin
							n_fill = nf;
							if (nf >= 4'd7) begin
								n_fill = 4'd0;
								if (ph.ok) do_start = 1'b1;
								else n_stopped = 1'b1;
							end
						end else begin
							n_left = left_q - 13'd1;
							if (n_left == 13'd0) frame_done = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
		hl = ph.f.pa ? asfs_pkg::HDR_LEN_NO_CRC : asfs_pkg::HDR_LEN_CRC;
		if (do_start) begin
			n_cur  = ph.f;
			n_fill = 4'd0;
			if (ph.f.len < {9'd0, hl}) begin
				n_stopped = 1'b1;
			end else begin
				n_left = ph.f.len - asfs_pkg::MIN_FRAME_LEN;
				if (n_left == 13'd0) frame_done = 1'b1;
			end
		end
		if (frame_done) n_total = total_q + 32'd1;
	end

	always_comb begin
		case (n_phase)
			PH_PROBE: sum_st = (n_fill == 4'd0) ? asfs_pkg::STS_EMPTY : asfs_pkg::STS_UNSUP;
			PH_SKIP: sum_st = (n_pos >= asfs_pkg::MP4_MIN_BYTES && n_ftyp) ?
				asfs_pkg::STS_MP4 : asfs_pkg::STS_UNSUP;
			PH_MP4: sum_st = asfs_pkg::STS_MP4;
			PH_FRAMES: begin
				if (n_total == 32'd0) sum_st = asfs_pkg::STS_HDR_ONLY;
				else if (n_stopped || n_fill != 4'd0 || n_left != 13'd0)
					sum_st = asfs_pkg::STS_PARTIAL;
				else sum_st = (n_tag != 29'd0) ? asfs_pkg::STS_FULL_TAG : asfs_pkg::STS_FULL;
			end
			default: sum_st = asfs_pkg::STS_UNSUP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			tag_q       <= '0;
			phase_q     <= PH_PROBE;
			left_q      <= '0;
			total_q     <= '0;
			stopped_q   <= 1'b0;
			fill_q      <= '0;
			ftyp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take && cmd.eos) begin
				pos_q     <= '0;
				tag_q     <= '0;
				phase_q   <= PH_PROBE;
				left_q    <= '0;
				total_q   <= '0;
				stopped_q <= 1'b0;
				fill_q    <= '0;
				ftyp_q    <= 1'b0;
			end else if (cmd.take) begin
				pos_q     <= n_pos;
				tag_q     <= n_tag;
				phase_q   <= n_phase;
				left_q    <= n_left;
				total_q   <= n_total;
				stopped_q <= n_stopped;
				fill_q    <= n_fill;
				ftyp_q    <= n_ftyp;
			end
			if (cmd.load_frame || cmd.load_sum) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			probe_q <= win;
			hdr_q   <= hbuf;
			first_q <= n_first;
			cur_q   <= n_cur;
		end
		if (cmd.take && cmd.eos) begin
			sum_st_q     <= sum_st;
			sum_adts_q   <= n_phase == PH_FRAMES;
			sum_first_q  <= n_first;
			sum_frames_q <= (n_phase == PH_FRAMES) ? n_total : 32'd0;
		end
		if (cmd.load_frame) begin
			res_q <= make_res(asfs_pkg::KIND_FRAME, asfs_pkg::STS_FULL, 1'b1, n_cur, n_total,
				32'd0, 1'b0);
		end else if (cmd.load_sum) begin
			res_q <= make_res(asfs_pkg::KIND_SUMMARY, sum_st_q, sum_adts_q, sum_first_q,
				sum_frames_q, sum_adts_q ? dur : 32'd0, 1'b1);
		end
	end

	assign sts.frame_done = frame_done;
	assign sts.out_valid  = out_valid_q;
	assign res            = res_q;
	assign div_frames     = sum_frames_q;
	assign div_rate       = asfs_pkg::rate_hz(sum_first_q.idx);

endmodule

FILE: src/adts_stream_frame_scanner.sv
// one byte transfer per cycle while the result register is free or being drained
// a frame result is registered on the edge that takes the frame's last byte
// the end marker adds a summary, loaded once the bit-serial duration divider has finished
// no byte is taken until the summary has been loaded into the result register
// arst_n clears all control state; the scanner then probes a fresh stream
// ---------------------------------------------------------------------------
// adts_stream_frame_scanner
// top level: adts / id3 / mp4 byte stream scanner with frame and summary results
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adts_stream_frame_scanner #(
	parameter int PROBE_WINDOW_BYTES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] data_byte
	input  logic         s_tuser,  // has_byte
	input  logic         s_tlast,  // end_of_stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [2:0] status, [5:3] profile, [9:6] rate_index, [26:10] sample_hz,
	// [29:27] channel_config, [42:30] frame_bytes, [46:43] header_bytes,
	// [78:47] frames_counted, [110:79] play_ms, [111] zero
	output logic [111:0] m_tdata,
	output logic         m_tuser,  // result_kind
	output logic         m_tlast   // last_result
);

	asfs_pkg::asfs_cmd_t cmd;
	asfs_pkg::asfs_sts_t sts;
	asfs_pkg::asfs_res_t res;
	logic                div_start;
	logic                div_done;
	logic [31:0]         div_quo;
	logic [31:0]         div_frames;
	logic [16:0]         div_rate;

	asfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tlast   (s_tlast),
		.m_tready  (m_tready),
		.sts       (sts),
		.div_done  (div_done),
		.s_tready  (s_tready),
		.cmd       (cmd),
		.div_start (div_start)
	);

	asfs_dp #(
		.PROBE_WINDOW_BYTES (PROBE_WINDOW_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (s_tdata),
		.has_byte   (s_tuser),
		.cmd        (cmd),
		.m_tready   (m_tready),
		.dur        (div_quo),
		.sts        (sts),
		.res        (res),
		.div_frames (div_frames),
		.div_rate   (div_rate)
	);

	asfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.frames (div_frames),
		.rate   (div_rate),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign m_tvalid = sts.out_valid;
	assign m_tuser  = res.kind;
	assign m_tlast  = res.last;
	assign m_tdata  = {1'b0, res.play_ms, res.frames_counted, res.header_bytes,
		res.frame_bytes, res.channel_config, res.sample_hz, res.rate_index, res.profile,
		res.status};

	`ASSERT_IMP(a_sum_is_last, m_tvalid && m_tuser == asfs_pkg::KIND_SUMMARY, m_tlast)
	`ASSERT_IMP(a_frame_clean, m_tvalid && res.kind == asfs_pkg::KIND_FRAME, res.play_ms == '0 && !m_tlast)
	`ASSERT_NXT(a_eos_holds_off, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule
